// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/wbsh_pkg.sv =====
// Package for the weighted byte sum hash: widths, constants, stage types
// and the coefficient ROM. No dependencies.
package wbsh_pkg;

   localparam int COEFF_COUNT  = 16;
   localparam int ROM_SIZE     = 16;
   localparam int RomIdxW      = $clog2(ROM_SIZE);
   localparam int CoeffW       = 9;
   localparam int WordW        = 32;
   localparam int ProdW        = WordW + CoeffW;
   localparam int SumW         = 64;
   localparam int ShiftW       = 4;
   localparam int HashW        = 31;
   localparam int Fold1W       = 38;
   localparam int FoldMul      = 19;   // 2^31 mod modulus

   localparam logic [HashW-1:0] HASH_MODULUS = 31'd2147483629;

   localparam logic [95:0] LcgMult = 96'h5DEECE66D;
   localparam logic [95:0] LcgAdd  = 96'hB;
   localparam logic [95:0] LcgSeed = 96'd2059879141;
   localparam logic [95:0] CoeffMod = 96'd257;

   typedef logic [CoeffW-1:0] coeff_rom_type [ROM_SIZE];

   // 48-bit LCG outputs (bits 47:17) reduced mod 257
   function automatic coeff_rom_type build_coeff_rom();
      coeff_rom_type rom;
      logic [95:0]   x;
      logic [95:0]   r;
      x = ((LcgSeed & 96'hFFFF_FFFF) << 16) | 96'h330E;
      for (int k = 0; k < ROM_SIZE; k++) begin
         x = (LcgMult * x + LcgAdd) & 96'hFFFF_FFFF_FFFF;
         r = (x >> 17) % CoeffMod;
         rom[k] = r[CoeffW-1:0];
      end
      return rom;
   endfunction

   localparam coeff_rom_type COEFF_ROM = build_coeff_rom();

   typedef struct packed {
      logic            valid;
      logic            last;
      logic [SumW-1:0] term;
   } term_stage_type;

   typedef struct packed {
      logic            valid;
      logic [SumW-1:0] sum;
   } sum_stage_type;

endpackage

// ===== design/wbsh_term.sv =====
// Term stage: sign-extends the byte, multiplies by the ROM coefficient and
// applies the weight shift. Depends on wbsh_pkg.
module wbsh_term import wbsh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output term_stage_type term_out
);

   logic [RomIdxW-1:0] coeff_idx_ff, coeff_idx_in;
   logic [ShiftW-1:0]  shift_ff, shift_in;
   term_stage_type     term_ff, term_in;
   logic [WordW-1:0]   word;
   logic [ProdW-1:0]   prod;
   logic [SumW-1:0]    prod_wide;

   always_comb begin
      word      = {{(WordW-8){in_byte[7]}}, in_byte};
      prod      = ProdW'(word) * ProdW'(COEFF_ROM[coeff_idx_ff]);
      prod_wide = {{(SumW-ProdW){1'b0}}, prod};

      term_in.valid = in_valid;
      term_in.last  = in_last;
      term_in.term  = prod_wide << shift_ff;

      coeff_idx_in = coeff_idx_ff;
      shift_in     = shift_ff;
      if (in_valid) begin
         if (in_last) begin
            coeff_idx_in = '0;
            shift_in     = '0;
         end else begin
            coeff_idx_in = (32'(coeff_idx_ff) >= COEFF_COUNT - 1) ? '0 : coeff_idx_ff + 1'b1;
            shift_in     = shift_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_idx_ff  <= '0;
         shift_ff      <= '0;
         term_ff.valid <= 1'b0;
      end else if (enable) begin
         coeff_idx_ff <= coeff_idx_in;
         shift_ff     <= shift_in;
         term_ff      <= term_in;
      end
   end

   assign term_out = term_ff;

endmodule

// ===== design/wbsh_accum.sv =====
// Accumulate stage: 64-bit wrapping running sum; hands the final sum on at
// the last byte and clears. Depends on wbsh_pkg.
module wbsh_accum import wbsh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  term_stage_type term_in,
   output sum_stage_type  sum_out
);

   logic [SumW-1:0] sum_ff, sum_in;
   sum_stage_type   out_ff, out_in;

   always_comb begin
      out_in.sum   = sum_ff + term_in.term;
      out_in.valid = term_in.valid && term_in.last;
      sum_in       = sum_ff;
      if (term_in.valid) begin
         sum_in = term_in.last ? '0 : out_in.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         sum_ff <= sum_in;
         out_ff <= out_in;
      end
   end

   assign sum_out = out_ff;

endmodule

// ===== design/wbsh_reduce.sv =====
// Reduction mod 2^31-19 in two folds (2^31 == 19) and a final subtract.
// Depends on wbsh_pkg.
module wbsh_reduce import wbsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  sum_stage_type    sum_in,
   output logic             hash_valid,
   output logic [HashW-1:0] hash_value
);

   logic              fold_valid_ff;
   logic [Fold1W-1:0] fold_ff, fold_in;
   logic              hash_valid_ff;
   logic [HashW-1:0]  hash_ff, hash_in;
   logic [HashW:0]    fold2;
   logic [HashW:0]    fold2_sub;

   always_comb begin
      fold_in = Fold1W'(sum_in.sum[SumW-1:HashW]) * Fold1W'(FoldMul)
              + Fold1W'(sum_in.sum[HashW-1:0]);
      // below twice the modulus here, so one subtract finishes it
      fold2 = (HashW+1)'(fold_ff[Fold1W-1:HashW]) * (HashW+1)'(FoldMul)
            + (HashW+1)'(fold_ff[HashW-1:0]);
      fold2_sub = fold2 - {1'b0, HASH_MODULUS};
      hash_in   = (fold2 >= {1'b0, HASH_MODULUS}) ? fold2_sub[HashW-1:0]
                                                  : fold2[HashW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         hash_valid_ff <= 1'b0;
      end else if (enable) begin
         fold_valid_ff <= sum_in.valid;
         fold_ff       <= fold_in;
         hash_valid_ff <= fold_valid_ff;
         hash_ff       <= hash_in;
      end
   end

   assign hash_valid = hash_valid_ff;
   assign hash_value = hash_ff;

endmodule

// ===== design/weighted_byte_sum_hash.sv =====
// Top level of the weighted byte sum hash.
// Depends on wbsh_pkg, wbsh_term, wbsh_accum and wbsh_reduce.

// One string byte is taken per cycle, back to back, unless the pipeline stalls.
// The hash of a string appears on the result channel after its last byte
// passes the input register, term multiply, 64-bit accumulate, first
// reduction fold and second fold into the result register. All stages move
// together: while a result is held with rsp_ready low the whole pipeline,
// and req_ready, stall.
module weighted_byte_sum_hash import wbsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_value,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [HashW-1:0] rsp_hash_value
);

   logic           enable;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   term_stage_type term_stage;
   sum_stage_type  sum_stage;

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_valid;
         in_byte_ff  <= req_byte_value;
         in_last_ff  <= req_last_byte;
      end
   end

   wbsh_term u_term (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .in_last  (in_last_ff),
      .term_out (term_stage)
   );

   wbsh_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .term_in (term_stage),
      .sum_out (sum_stage)
   );

   wbsh_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .sum_in     (sum_stage),
      .hash_valid (rsp_valid),
      .hash_value (rsp_hash_value)
   );

endmodule

// ===== design/wbsh_checker.sv =====
// Port-level checks for the weighted byte sum hash, bound to the top level.
// Depends on wbsh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wbsh_checker import wbsh_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [7:0]       req_byte_value,
   input logic             req_last_byte,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [HashW-1:0] rsp_hash_value
);

   logic       rsp_stall;
   logic       req_stall;
   logic [8:0] req_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_stall   = req_valid && !req_ready;
   assign req_payload = {req_last_byte, req_byte_value};

   // held transactions keep their values on both channels
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_hash_value), "rsp changed")
   `ASSERT_CLK(a_req_hold, clock, reset, req_stall |=> req_valid && $stable(req_payload), "req changed")
   `ASSERT_CLK(a_hash_range, clock, reset, rsp_valid |-> rsp_hash_value < HASH_MODULUS, "hash not reduced")
   `ASSERT_CLK_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")
   // a stalled result stalls the input side too
   `ASSERT_CLK(a_stall_input, clock, reset, rsp_stall |-> !req_ready, "input taken while stalled")

endmodule

bind weighted_byte_sum_hash wbsh_checker u_wbsh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_byte_value (req_byte_value),
   .req_last_byte  (req_last_byte),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);

// ===== dv/wbsh_tb_pkg.sv =====
// Scoreboard for the weighted byte sum hash testbench: a cycle-free model of
// the hash and the queue of pending string hashes. Depends on wbsh_pkg.
package wbsh_tb_pkg;

   localparam int unsigned CoeffCount   = 16;
   localparam int unsigned RomDepth     = 16;
   localparam int unsigned WeightSteps  = 16;
   localparam int          MaxReports   = 10;
   localparam logic [63:0] GenMult      = 64'h5DEECE66D;
   localparam logic [63:0] GenAdd       = 64'hB;
   localparam logic [63:0] GenSeed      = 64'd2059879141;
   localparam logic [63:0] GenLowWord   = 64'h330E;
   localparam logic [63:0] GenMask      = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] CoeffModulus = 64'd257;
   localparam logic [63:0] HashModulus  = 64'd2147483629;

   class hash_scoreboard;
      logic [8:0]                 coeff_table [RomDepth];
      logic [63:0]                running_sum;
      int unsigned                coeff_idx;
      int unsigned                shift_amt;
      logic [wbsh_pkg::HashW-1:0] pending_hashes [$];
      int unsigned                mismatches;

      function new();
         logic [63:0] gen;
         logic [63:0] draw;
         // 48-bit LCG, upper 31 bits of each step, reduced mod 257
         gen = ((GenSeed & 64'hFFFF_FFFF) << 16) | GenLowWord;
         for (int k = 0; k < RomDepth; k++) begin
            gen = (GenMult * gen + GenAdd) & GenMask;
            draw = (gen >> 17) % CoeffModulus;
            coeff_table[k] = draw[8:0];
         end
         running_sum = '0;
         coeff_idx   = 0;
         shift_amt   = 0;
         mismatches  = 0;
      endfunction

      function void note_byte(logic [7:0] value, logic last);
         logic [63:0] word;
         logic [63:0] term;
         logic [63:0] hash;
         // byte is a signed char widened to a 32-bit unsigned word
         word = value[7] ? {32'h0, 24'hFF_FFFF, value} : {56'h0, value};
         term = (word * {55'h0, coeff_table[coeff_idx % RomDepth]}) << shift_amt;
         running_sum = running_sum + term;
         if (last) begin
            hash = running_sum % HashModulus;
            pending_hashes.push_back(hash[wbsh_pkg::HashW-1:0]);
            running_sum = '0;
            coeff_idx   = 0;
            shift_amt   = 0;
         end else begin
            coeff_idx = (coeff_idx + 1 == CoeffCount) ? 0 : coeff_idx + 1;
            shift_amt = (shift_amt + 1) % WeightSteps;
         end
      endfunction

      function void check_hash(logic [wbsh_pkg::HashW-1:0] actual);
         logic [wbsh_pkg::HashW-1:0] expected;
         if (pending_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("hash %0d arrived with no string pending", actual);
            return;
         end
         expected = pending_hashes.pop_front();
         if (actual !== expected) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("hash_value mismatch: expected %0d actual %0d", expected, actual);
         end
      endfunction
   endclass

endpackage

// ===== dv/weighted_byte_sum_hash_tb.sv =====
// Top-level testbench for weighted_byte_sum_hash: drives strings byte by byte
// with random idling and back-pressure. Depends on wbsh_pkg and wbsh_tb_pkg.
module weighted_byte_sum_hash_tb import wbsh_tb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int LongHold   = 300;
   localparam int PhaseBytes = 580;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_byte_value = 8'h00;
   logic                       req_last_byte  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [wbsh_pkg::HashW-1:0] rsp_hash_value;

   hash_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int cycle_count;

   weighted_byte_sum_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   // observe both channels on the edge a transaction completes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_byte_value, req_last_byte);
         if (rsp_valid && rsp_ready) sb.check_hash(rsp_hash_value);
      end
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LongHold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= value;
      req_last_byte  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_string(input int len);
      logic [7:0] value;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0:       value = 8'h00;
               1:       value = 8'h7F;
               2:       value = 8'h80;
               default: value = 8'hFF;
            endcase
         end else begin
            value = 8'($urandom_range(255));
         end
         send_byte(value, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending_hashes.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase_bytes;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 74;

      // single-byte strings at the byte extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b1);
      // long negative string: coefficient index and shift both wrap
      for (int i = 0; i < 18; i++) send_byte(i[0] ? 8'h80 : 8'hFF, i == 17);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // sender holds off until every pending hash is out
         req_valid <= 1'b0;
         wait_drained();
         phase_bytes = 0;
         if (phase == 2) begin
            // receiver blocks while short strings keep coming, so the pipe backs up
            hold_requests <= hold_requests + 1;
            while (phase_bytes < 80) begin
               len = $urandom_range(3, 1);
               send_string(len);
               phase_bytes += len;
            end
         end
         while (phase_bytes < PhaseBytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 21) : $urandom_range(20, 1);
            send_string(len);
            phase_bytes += len;
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_hashes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
